### rtl/spc_pkg.sv
// shared types and constants for the stepper position controller
package spc_pkg;

   localparam int unsigned ANGLE_W = 8;
   localparam int unsigned STEP_W  = 12;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned COIL_W  = 4;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // angle offset to zero base, step scale 1667/100 = 16 + 67/100
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -8'sd100;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 8'sd100;
   localparam logic [ANGLE_W:0]           ANGLE_OFS = 9'd100;
   localparam logic [13:0]                FRAC_MUL  = 14'd67;
   localparam logic [12:0]                RECIP_100 = 13'd5243;
   localparam int unsigned                RECIP_SH  = 19;
   localparam logic [STEP_W-1:0]          STEP_OFS  = 12'd1667;
   localparam logic signed [STEP_W-1:0]   STEP_MIN  = -12'sd1667;
   localparam logic signed [STEP_W-1:0]   STEP_MAX  = 12'sd1667;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;
   localparam logic [CSR_W-1:0]   FWD_RESET   = 16'h8421;
   localparam logic [CSR_W-1:0]   REV_RESET   = 16'h1248;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_MOVE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_DELAY = 2'd0,
      CSR_FWD_PAT    = 2'd1,
      CSR_REV_PAT    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic                      func;
      logic signed [ANGLE_W-1:0] move_angle;
   } req_type;

   typedef struct packed {
      logic [COIL_W-1:0]        coil_drive;
      logic                     drive_update;
      logic                     running;
      logic signed [STEP_W-1:0] target_position;
      logic signed [STEP_W-1:0] current_position;
   } rsp_type;

   function automatic logic [COIL_W-1:0] pick_pattern(input logic [CSR_W-1:0] table_v,
                                                      input logic [1:0] idx);
      logic [COIL_W-1:0] pat;
      case (idx)
         2'd0:    pat = table_v[3:0];
         2'd1:    pat = table_v[7:4];
         2'd2:    pat = table_v[11:8];
         default: pat = table_v[15:12];
      endcase
      return pat;
   endfunction

endpackage

### rtl/stepper_position_controller_top.sv
// stepper position controller top level
// One beat in, one beat out. An accepted beat passes two registers before its result is offered:
// an input register holds the clamped angle and its partial product, and the result register then takes
// the updated motor state. A beat can be taken every cycle; the
// throughput is one beat per cycle as long as the result side keeps taking beats, and the input
// stalls only while a held result is not taken and the input register is also full.
module stepper_position_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  spc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output spc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [spc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spc_pkg::CSR_W-1:0]           csr_wdata
);

   // configuration
   logic [spc_pkg::DELAY_W-1:0] step_delay_ff;
   logic [spc_pkg::CSR_W-1:0]   fwd_pat_ff;
   logic [spc_pkg::CSR_W-1:0]   rev_pat_ff;

   // input stage
   logic                        in_valid_ff;
   logic                        in_func_ff;
   logic [spc_pkg::ANGLE_W-1:0] in_ofs_ff;
   logic [13:0]                 in_frac_ff;

   // motor state
   logic signed [spc_pkg::STEP_W-1:0] pos_ff, pos_in;
   logic signed [spc_pkg::STEP_W-1:0] target_ff, target_in;
   logic                              fwd_ff, fwd_in;
   logic                              active_ff, active_in;
   logic [spc_pkg::DELAY_W-1:0]       elapsed_ff, elapsed_in;
   logic [spc_pkg::COIL_W-1:0]        coils_ff, coils_in;
   logic                              update_in;

   // result stage
   logic              rsp_valid_ff;
   spc_pkg::rsp_type  rsp_data_ff;

   logic out_free;
   logic advance;
   logic req_fire;

   // angle clamp and first partial product
   logic signed [spc_pkg::ANGLE_W-1:0] angle_sat;
   logic [spc_pkg::ANGLE_W:0]          ofs_wide;
   logic [spc_pkg::ANGLE_W-1:0]        ofs;
   logic [13:0]                        frac_prod;

   // second stage arithmetic
   logic [26:0]                        recip_prod;
   logic [spc_pkg::STEP_W-1:0]         frac_q;
   logic signed [spc_pkg::STEP_W-1:0]  move_target;
   logic [spc_pkg::DELAY_W-1:0]        elapsed_inc;
   logic signed [spc_pkg::STEP_W:0]    left;
   logic                               steps_left;
   logic [spc_pkg::COIL_W-1:0]         pattern;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_data.move_angle < spc_pkg::ANGLE_MIN) begin
         angle_sat = spc_pkg::ANGLE_MIN;
      end else if (req_data.move_angle > spc_pkg::ANGLE_MAX) begin
         angle_sat = spc_pkg::ANGLE_MAX;
      end else begin
         angle_sat = req_data.move_angle;
      end
      ofs_wide  = {angle_sat[spc_pkg::ANGLE_W-1], angle_sat} + spc_pkg::ANGLE_OFS;
      ofs       = ofs_wide[spc_pkg::ANGLE_W-1:0];
      frac_prod = {6'd0, ofs} * spc_pkg::FRAC_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_delay_ff <= spc_pkg::DELAY_RESET;
         fwd_pat_ff    <= spc_pkg::FWD_RESET;
         rev_pat_ff    <= spc_pkg::REV_RESET;
      end else if (csr_we) begin
         case (spc_pkg::csr_idx_type'(csr_index))
            spc_pkg::CSR_STEP_DELAY: step_delay_ff <= csr_wdata;
            spc_pkg::CSR_FWD_PAT:    fwd_pat_ff    <= csr_wdata;
            spc_pkg::CSR_REV_PAT:    rev_pat_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff <= req_data.func;
         in_ofs_ff  <= ofs;
         in_frac_ff <= frac_prod;
      end
   end

   always_comb begin
      recip_prod  = {13'd0, in_frac_ff} * {14'd0, spc_pkg::RECIP_100};
      frac_q      = {4'd0, recip_prod[spc_pkg::RECIP_SH +: 8]};
      move_target = $signed({in_ofs_ff, 4'd0} + frac_q - spc_pkg::STEP_OFS);

      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 16'd1;
      left        = fwd_ff ? ({target_ff[spc_pkg::STEP_W-1], target_ff}
                              - {pos_ff[spc_pkg::STEP_W-1], pos_ff})
                           : ({pos_ff[spc_pkg::STEP_W-1], pos_ff}
                              - {target_ff[spc_pkg::STEP_W-1], target_ff});
      steps_left  = !left[spc_pkg::STEP_W] && (left != '0);
      pattern     = fwd_ff ? spc_pkg::pick_pattern(fwd_pat_ff, left[1:0])
                           : spc_pkg::pick_pattern(rev_pat_ff, left[1:0]);

      pos_in     = pos_ff;
      target_in  = target_ff;
      fwd_in     = fwd_ff;
      active_in  = active_ff;
      elapsed_in = elapsed_ff;
      coils_in   = coils_ff;
      update_in  = 1'b0;

      if (in_func_ff == spc_pkg::FUNC_MOVE) begin
         target_in = move_target;
         fwd_in    = move_target > pos_ff;
         active_in = 1'b1;
      end else begin
         elapsed_in = elapsed_inc;
         if (active_ff && (elapsed_inc >= step_delay_ff)) begin
            update_in = 1'b1;
            if (steps_left) begin
               coils_in   = pattern;
               pos_in     = fwd_ff ? pos_ff + 12'sd1 : pos_ff - 12'sd1;
               elapsed_in = '0;
            end else begin
               coils_in  = '0;
               active_in = 1'b0;
               target_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         target_ff  <= '0;
         fwd_ff     <= 1'b0;
         active_ff  <= 1'b0;
         elapsed_ff <= '0;
         coils_ff   <= '0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         target_ff  <= target_in;
         fwd_ff     <= fwd_in;
         active_ff  <= active_in;
         elapsed_ff <= elapsed_in;
         coils_ff   <= coils_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.coil_drive       <= coils_in;
         rsp_data_ff.drive_update     <= update_in;
         rsp_data_ff.running          <= active_in;
         rsp_data_ff.target_position  <= target_in;
         rsp_data_ff.current_position <= pos_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a move beat always reports a running motor
   a_move_runs: assert property (@(posedge clock) disable iff (reset)
      advance && (in_func_ff == spc_pkg::FUNC_MOVE) |=> rsp_valid_ff && rsp_data_ff.running)
      else $error("move beat did not start the motor");

   // an idle motor holds a zero target
   a_idle_target: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (target_ff == '0))
      else $error("idle motor with non-zero target");

   // a stop drives all coils low
   a_stop_coils: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.drive_update && !rsp_data_ff.running
      |-> (rsp_data_ff.coil_drive == '0))
      else $error("stop beat left coils driven");

   // position stays within the step range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff >= spc_pkg::STEP_MIN) && (pos_ff <= spc_pkg::STEP_MAX))
      else $error("position out of range");
`endif

endmodule
